// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file wrbd_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define WRBD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a signal holds in the cycle after a condition
`define WRBD_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

// ===== hdl/wrbd_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types of the wrist roll bite detector
// no dependencies
package wrbd_pkg;

	localparam int WINDOW_LEN_DEF  = 15;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int THR_W    = 15;
	localparam int DWELL_W  = 12;
	localparam int DCNT_W   = 13;
	localparam int TOTAL_W  = 16;
	localparam int INDEX_W  = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;
	localparam int OUT_TDATA_W = 48;

	localparam logic [THR_W-1:0]   THR_RESET    = THR_W'(160);
	localparam logic [DWELL_W-1:0] DWELL1_RESET = DWELL_W'(30);
	localparam logic [DWELL_W-1:0] DWELL2_RESET = DWELL_W'(120);
	localparam logic [DCNT_W-1:0]  DCNT_MAX     = {DCNT_W{1'b1}};
	localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DWELL1    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DWELL2    = 2'd2;

	// phase codes
	localparam logic [1:0] PH_WAIT_POS = 2'd0;
	localparam logic [1:0] PH_DWELL1   = 2'd1;
	localparam logic [1:0] PH_WAIT_NEG = 2'd2;
	localparam logic [1:0] PH_DWELL2   = 2'd3;

	typedef struct packed {
		logic [THR_W-1:0]   threshold;
		logic [DWELL_W-1:0] dwell1;
		logic [DWELL_W-1:0] dwell2;
	} cfg_t;

endpackage

// ===== hdl/wrbd_window.sv =====
`timescale 1ns / 1ps
// sample window memory and running sum, one request in flight in stage s1
// depends on wrbd_pkg
module wrbd_window import wrbd_pkg::*; #(
	parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          step,
	output logic                          valid_s1,
	output logic signed [SUM_W-1:0]       sum_next
);

	localparam int PW = $clog2(WINDOW_LEN);

	logic signed [SAMPLE_BITS-1:0] mem [WINDOW_LEN];
	logic signed [SAMPLE_BITS-1:0] rdata_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic [PW-1:0]                 pos_s1;
	logic                          first_s1;
	logic [PW-1:0]                 pos_q;
	logic                          wrapped_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [SAMPLE_BITS-1:0] old_val;

	always_ff @(posedge clk) begin
		if (step) begin
			mem[pos_s1] <= x_s1;
		end
		if (accept) begin
			rdata_s1 <= mem[pos_q];
			x_s1     <= sample;
			pos_s1   <= pos_q;
			first_s1 <= !wrapped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (accept) begin
				if (pos_q == PW'(WINDOW_LEN - 1)) begin
					pos_q     <= '0;
					wrapped_q <= 1'b1;
				end else begin
					pos_q <= pos_q + PW'(1);
				end
			end
			if (step) begin
				sum_q <= sum_next;
			end
		end
	end

	// entries not yet written on the first pass read as zero
	assign old_val  = first_s1 ? '0 : rdata_s1;
	assign sum_next = sum_q + SUM_W'(x_s1) - SUM_W'(old_val);

endmodule

// ===== hdl/wrbd_phase.sv =====
`timescale 1ns / 1ps
// phase machine, counters and result register
// depends on wrbd_pkg
module wrbd_phase import wrbd_pkg::*; #(
	parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    step,
	input  logic signed [SUM_W-1:0] sum,
	input  logic                    out_ready,
	output logic                    out_valid_q,
	output logic                    out_seen_q,
	output logic [TOTAL_W-1:0]      out_total_q,
	output logic [INDEX_W-1:0]      out_index_q
);

	localparam int LIM_W = THR_W + $clog2(WINDOW_LEN + 1);
	localparam int CMP_W = ((SUM_W > LIM_W) ? SUM_W : LIM_W) + 2;
	localparam int FW    = $clog2(WINDOW_LEN);

	logic [1:0]          phase_q;
	logic [DCNT_W-1:0]   dwell_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [INDEX_W-1:0]  index_q;
	logic [FW-1:0]       fill_q;
	logic [LIM_W-1:0]    limit;
	logic signed [CMP_W-1:0] sum_c;
	logic signed [CMP_W-1:0] lim_c;
	logic                filling;
	logic [1:0]          ph;
	logic [DCNT_W-1:0]   dc;
	logic [TOTAL_W-1:0]  tot;
	logic                seen;

	assign limit   = LIM_W'(cfg.threshold) * LIM_W'(WINDOW_LEN);
	assign sum_c   = CMP_W'(sum);
	assign lim_c   = signed'(CMP_W'(limit));
	assign filling = fill_q < FW'(WINDOW_LEN - 1);

	// checks fall through in phase order, each sees the phase left by the one before
	always_comb begin
		ph   = phase_q;
		dc   = dwell_q;
		tot  = total_q;
		seen = 1'b0;
		if (!filling) begin
			if (ph == PH_WAIT_POS && sum_c > lim_c) begin
				ph = PH_DWELL1;
				dc = '0;
			end
			if (ph == PH_DWELL1) begin
				if (dc != DCNT_MAX) begin
					dc = dc + DCNT_W'(1);
				end
				if (dc > {1'b0, cfg.dwell1}) begin
					ph = PH_WAIT_NEG;
				end
			end
			if (ph == PH_WAIT_NEG && sum_c < -lim_c) begin
				ph   = PH_DWELL2;
				dc   = '0;
				seen = 1'b1;
				if (tot != TOTAL_MAX) begin
					tot = tot + TOTAL_W'(1);
				end
			end
			if (ph == PH_DWELL2) begin
				if (dc != DCNT_MAX) begin
					dc = dc + DCNT_W'(1);
				end
				if (dc > {1'b0, cfg.dwell2}) begin
					ph = PH_WAIT_POS;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT_POS;
			dwell_q     <= '0;
			total_q     <= '0;
			index_q     <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= ph;
				dwell_q <= dc;
				total_q <= tot;
				index_q <= index_q + INDEX_W'(1);
				if (filling) begin
					fill_q <= fill_q + FW'(1);
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_seen_q  <= seen;
			out_total_q <= tot;
			out_index_q <= index_q;
		end
	end

endmodule

// ===== hdl/wrist_roll_bite_detector_unit.sv =====
`timescale 1ns / 1ps
// channel   dir  tdata / fields
// s_axis    in   roll_rate (signed SAMPLE_BITS)
// m_axis    out  bite_seen, bite_total, sample_number
// cfg       in   write only: roll_threshold, first_dwell, second_dwell
//
// one sample per cycle sustained while the result output is not stalled; a sample is
// registered in stage s1 as the window memory is read at its request edge, and the sum
// and phase step land in the result register once the output is free.
// the window memory needs no clearing pass: the first lap reads as zero.
// a stalled result output holds one more sample in stage s1 before s_tready drops.
// depends on wrbd_pkg, wrbd_window, wrbd_phase
module wrist_roll_bite_detector_unit import wrbd_pkg::*; #(
	parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int IN_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_W-1:0]        s_tdata,   // roll_rate
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // bite_seen, bite_total, sample_number
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN);

	cfg_t                    cfg_q;
	logic                    accept;
	logic                    step;
	logic                    valid_s1;
	logic                    out_free;
	logic signed [SUM_W-1:0] sum_next;
	logic                    out_seen;
	logic [TOTAL_W-1:0]      out_total;
	logic [INDEX_W-1:0]      out_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THR_RESET;
			cfg_q.dwell1    <= DWELL1_RESET;
			cfg_q.dwell2    <= DWELL2_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold <= cfg_wdata[THR_W-1:0];
				REG_DWELL1:    cfg_q.dwell1    <= cfg_wdata[DWELL_W-1:0];
				REG_DWELL2:    cfg_q.dwell2    <= cfg_wdata[DWELL_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !m_tvalid || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	wrbd_window #(
		.WINDOW_LEN  (WINDOW_LEN),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.sample   (signed'(s_tdata[SAMPLE_BITS-1:0])),
		.step     (step),
		.valid_s1 (valid_s1),
		.sum_next (sum_next)
	);

	wrbd_phase #(
		.WINDOW_LEN  (WINDOW_LEN),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_phase (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.step        (step),
		.sum         (sum_next),
		.out_ready   (m_tready),
		.out_valid_q (m_tvalid),
		.out_seen_q  (out_seen),
		.out_total_q (out_total),
		.out_index_q (out_index)
	);

	assign m_tdata = {
		(OUT_TDATA_W - 1 - TOTAL_W - INDEX_W)'(0), out_index, out_total, out_seen
	};

endmodule

// ===== hdl/wrbd_checker.sv =====
`timescale 1ns / 1ps
// port level checks of the bite detector, bound to the top level
// depends on wrbd_pkg, assert_macros.svh, wrist_roll_bite_detector_unit
`include "assert_macros.svh"

module wrbd_checker import wrbd_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	`WRBD_ASSERT(a_result_held, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`WRBD_ASSERT_HOLD(a_payload_held, clk, arst_n, m_tvalid && !m_tready, m_tdata, "stalled result changed")
	`WRBD_ASSERT(a_ready_when_empty, clk, arst_n, !m_tvalid |-> s_tready, "input blocked with empty output")
	`WRBD_ASSERT(a_bite_counted, clk, arst_n, m_tvalid && m_tdata[0] |-> m_tdata[16:1] != 16'd0, "bite reported with zero total")

endmodule

bind wrist_roll_bite_detector_unit wrbd_checker u_wrbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== dv/tb_wrist_roll_bite_detector_unit.sv =====
`timescale 1ns / 1ps
// self-checking bench for wrist_roll_bite_detector_unit: roll-rate samples in, one bite
// result out per sample, checked against an in-bench model of the running sum and phase machine
// depends on wrbd_pkg and the detector rtl
module tb_wrist_roll_bite_detector_unit import wrbd_pkg::*; ();

	localparam int WIN = WINDOW_LEN_DEF;
	localparam int STALL_LIMIT = 1000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic               seen;
		logic [TOTAL_W-1:0] total;
		logic [INDEX_W-1:0] index;
	} bite_result_t;

	class bite_scoreboard;
		logic signed [SAMPLE_BITS_DEF-1:0] window [WIN];
		int wpos;
		int wsum;
		int fill;
		logic [1:0] phase;
		logic [DCNT_W-1:0] dcount;
		logic [TOTAL_W-1:0] bites;
		logic [INDEX_W-1:0] index;
		cfg_t cfg;
		bite_result_t outstanding[$];
		int mismatches;

		function new();
			foreach (window[i])
				window[i] = '0;
			wpos = 0;
			wsum = 0;
			fill = 0;
			phase = PH_WAIT_POS;
			dcount = '0;
			bites = '0;
			index = '0;
			cfg.threshold = THR_RESET;
			cfg.dwell1 = DWELL1_RESET;
			cfg.dwell2 = DWELL2_RESET;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_THRESHOLD: cfg.threshold = v[THR_W-1:0];
				REG_DWELL1:    cfg.dwell1 = v[DWELL_W-1:0];
				REG_DWELL2:    cfg.dwell2 = v[DWELL_W-1:0];
				default: ;
			endcase
		endfunction

		// one accepted request: advance the window and phase machine, queue the result
		function void note_sample(logic [SAMPLE_BITS_DEF-1:0] raw);
			logic signed [SAMPLE_BITS_DEF-1:0] x;
			int lim;
			bite_result_t r;
			x = raw;
			r.seen = 1'b0;
			wsum += int'(x) - int'(window[wpos]);
			window[wpos] = x;
			wpos = (wpos + 1) % WIN;
			if (fill < WIN - 1) begin
				fill++;
			end else begin
				lim = int'(cfg.threshold) * WIN;
				if (phase == PH_WAIT_POS && wsum > lim) begin
					phase = PH_DWELL1;
					dcount = '0;
				end
				if (phase == PH_DWELL1) begin
					if (dcount != DCNT_MAX)
						dcount++;
					if (dcount > DCNT_W'(cfg.dwell1))
						phase = PH_WAIT_NEG;
				end
				if (phase == PH_WAIT_NEG && wsum < -lim) begin
					phase = PH_DWELL2;
					dcount = '0;
					r.seen = 1'b1;
					if (bites != TOTAL_MAX)
						bites++;
				end
				if (phase == PH_DWELL2) begin
					if (dcount != DCNT_MAX)
						dcount++;
					if (dcount > DCNT_W'(cfg.dwell2))
						phase = PH_WAIT_POS;
				end
			end
			r.total = bites;
			r.index = index;
			index++;
			outstanding.push_back(r);
		endfunction

		function void complain(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] d);
			bite_result_t want;
			bite_result_t got;
			got.seen = d[0];
			got.total = d[TOTAL_W:1];
			got.index = d[TOTAL_W+INDEX_W:TOTAL_W+1];
			if (outstanding.size() == 0) begin
				complain($sformatf("result with nothing outstanding, sample_number %0d", got.index));
				return;
			end
			want = outstanding.pop_front();
			if (got.seen !== want.seen)
				complain($sformatf("sample %0d bite_seen expected %0b got %0b",
					want.index, want.seen, got.seen));
			if (got.total !== want.total)
				complain($sformatf("sample %0d bite_total expected %0d got %0d",
					want.index, want.total, got.total));
			if (got.index !== want.index)
				complain($sformatf("sample_number expected %0d got %0d", want.index, got.index));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b1;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	bite_scoreboard sb;
	bit pace_idle = 1'b1;
	bit tvalid_on = 1'b0;
	int ready_hold = 0;
	int quiet_cycles = 0;
	int samples_sent = 0;

	wrist_roll_bite_detector_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// result side: check each accepted result, then, when paced, stall ready for a random spell
	always @(posedge clk) begin
		int draw;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata);
				draw = pace_idle ? $urandom_range(0, 4) : 0;
				if (draw != 0) begin
					m_tready <= 1'b0;
					ready_hold <= draw;
				end
			end else if (ready_hold != 0) begin
				ready_hold <= ready_hold - 1;
				if (ready_hold == 1)
					m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("[wrist_roll_bite_detector_unit] ERROR");
				$finish;
			end
		end
	end

	function automatic logic [15:0] clamp16(int v);
		if (v > 32767)
			return 16'h7FFF;
		if (v < -32768)
			return 16'h8000;
		return 16'(v);
	endfunction

	// drop valid only when it is still raised, so it is driven once per edge
	task automatic stop_stream();
		if (tvalid_on) begin
			s_tvalid <= 1'b0;
			tvalid_on = 1'b0;
		end
	endtask

	task automatic send_sample(logic [15:0] v);
		int gap;
		gap = pace_idle ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			stop_stream();
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		tvalid_on = 1'b1;
		s_tdata <= v;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_sample(v);
		samples_sent++;
	endtask

	// registers only change once every outstanding request has come back
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		stop_stream();
		while (sb.outstanding.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	task automatic set_config(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] d1,
			logic [CFG_DATA_W-1:0] d2);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_DWELL1, d1);
		write_reg(REG_DWELL2, d2);
	endtask

	// positive swing, pause, negative swing, pause, each with random length and content
	task automatic play_gesture();
		int level;
		int quiet_max;
		int v;
		level = int'(sb.cfg.threshold);
		quiet_max = (sb.cfg.dwell1 > 40) ? 44 : int'(sb.cfg.dwell1) + 4;
		repeat ($urandom_range(4, 24)) begin
			v = level + int'($urandom_range(0, level / 2 + 200));
			send_sample(clamp16(v));
		end
		repeat ($urandom_range(0, quiet_max)) begin
			v = int'($urandom_range(0, 64)) - 32;
			send_sample(clamp16(v));
		end
		repeat ($urandom_range(4, 24)) begin
			v = -level - int'($urandom_range(0, level / 2 + 200));
			send_sample(clamp16(v));
		end
		repeat ($urandom_range(0, quiet_max)) begin
			v = int'($urandom_range(0, 64)) - 32;
			send_sample(clamp16(v));
		end
	endtask

	task automatic run_chunk(int count);
		int stop_at;
		stop_at = samples_sent + count;
		pace_idle = ($urandom_range(0, 3) != 0);
		while (samples_sent < stop_at) begin
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 6))
					send_sample(16'($urandom()));
			end else begin
				play_gesture();
			end
		end
		stop_stream();
	endtask

	initial begin
		logic [15:0] extreme_vals [8];
		int amp;
		extreme_vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
			16'h0001, 16'h5555, 16'hAAAA, 16'h7FFF};
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes while the window fills, then zero threshold and dwells so that a
		// single sample runs through several phases
		foreach (extreme_vals[i])
			send_sample(extreme_vals[i]);
		set_config('0, '0, '0);
		repeat (6) begin
			send_sample(16'h7FFF);
			send_sample(16'h8000);
		end
		write_reg(REG_UNUSED, 15'($urandom()));
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		set_config(CFG_DATA_W'(THR_RESET), CFG_DATA_W'(DWELL1_RESET), CFG_DATA_W'(DWELL2_RESET));

		run_chunk(150);
		set_config('0, '0, '0);
		run_chunk(100);
		// dwell writes carry bits above the register width that must be dropped
		set_config(15'h7FFF, 15'h7FFF, 15'h7FFF);
		run_chunk(60);
		write_reg(REG_UNUSED, '0);
		repeat (6) begin
			if ($urandom_range(0, 2) == 0)
				set_config(15'($urandom()), 15'($urandom()), 15'($urandom()));
			else
				set_config(15'($urandom_range(0, 3000)), 15'($urandom_range(0, 20)),
					15'($urandom_range(0, 40)));
			write_reg(REG_UNUSED, 15'($urandom()));
			run_chunk(100);
		end

		// alternating signs flip the window sum every sample, a bite every two samples
		set_config('0, '0, '0);
		pace_idle = 1'b0;
		amp = $urandom_range(1, 32767);
		repeat (50) begin
			send_sample(clamp16(amp));
			send_sample(clamp16(-amp));
		end
		pace_idle = 1'b1;
		run_chunk(40);

		while (sb.outstanding.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding.size() == 0)
			$display("[wrist_roll_bite_detector_unit] OK");
		else
			$display("[wrist_roll_bite_detector_unit] ERROR");
		$finish;
	end

endmodule
